// File: rtl/core/jsu_pkg.sv
package jsu_pkg;

  // result limits per input request
  localparam int MAX_RES = 4;
  localparam int IDXW    = $clog2(MAX_RES);
  localparam int CNTW    = $clog2(MAX_RES + 1);

  // packet queue depth
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // error codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_NO_OPEN    = 4'd1;
  localparam logic [3:0] ERR_CONTROL    = 4'd2;
  localparam logic [3:0] ERR_INCOMPLETE = 4'd3;
  localparam logic [3:0] ERR_UNKNOWN    = 4'd4;
  localparam logic [3:0] ERR_SHORT_UNI  = 4'd5;
  localparam logic [3:0] ERR_BAD_HEX    = 4'd6;
  localparam logic [3:0] ERR_BAD_PAIR   = 4'd7;
  localparam logic [3:0] ERR_UNCLOSED   = 4'd8;

  // character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [7:0] MAP_BS = 8'h08;
  localparam logic [7:0] MAP_FF = 8'h0C;
  localparam logic [7:0] MAP_LF = 8'h0A;
  localparam logic [7:0] MAP_CR = 8'h0D;
  localparam logic [7:0] MAP_HT = 8'h09;

  // code point limits
  localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
  localparam logic [20:0] PAIR_OFFSET   = 21'h10000;
  localparam logic [20:0] CP_1B_MAX     = 21'h7F;
  localparam logic [20:0] CP_2B_MAX     = 21'h7FF;
  localparam logic [20:0] CP_3B_MAX     = 21'hFFFF;
  localparam int          LONE_BYTES    = 3;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic [3:0] error_code;
  } res_t;

  // all results of one input request
  typedef struct packed {
    logic [CNTW-1:0]          n;
    res_t [MAX_RES-1:0]       ent;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [CNTW-1:0]          n;
    logic [MAX_RES-1:0][7:0]  b;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       known;
    logic [7:0] ch;
  } esc_t;

  function automatic res_t res_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  function automatic res_t res_err(input logic [3:0] code);
    res_t r;
    r = '0;
    r.error_code = code;
    return r;
  endfunction

  function automatic res_t res_end();
    res_t r;
    r = '0;
    r.string_end = 1'b1;
    return r;
  endfunction

  // utf-8 encoding of a code point, first byte in b[0]
  function automatic utf8_t jsu_utf8(input logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp <= CP_1B_MAX) begin
      u.n    = CNTW'(1);
      u.b[0] = {1'b0, cp[6:0]};
    end else if (cp <= CP_2B_MAX) begin
      u.n    = CNTW'(2);
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= CP_3B_MAX) begin
      u.n    = CNTW'(3);
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.n    = CNTW'(4);
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

  // hex digit value
  function automatic hex_t jsu_hex(input logic [7:0] b);
    hex_t h;
    h = '0;
    case (b) inside
      [CH_0:CH_9]: begin
        h.ok  = 1'b1;
        h.val = 4'(b - CH_0);
      end
      [CH_LA:CH_LF]: begin
        h.ok  = 1'b1;
        h.val = 4'(b - CH_LA + 8'd10);
      end
      [CH_UA:CH_UF]: begin
        h.ok  = 1'b1;
        h.val = 4'(b - CH_UA + 8'd10);
      end
      default: h = '0;
    endcase
    return h;
  endfunction

  // simple escape map, u and unknown escapes give known = 0
  function automatic esc_t jsu_esc(input logic [7:0] b);
    esc_t e;
    e.known = 1'b1;
    e.ch    = b;
    case (b)
      CH_QUOTE: e.ch = CH_QUOTE;
      CH_BSL:   e.ch = CH_BSL;
      CH_SLASH: e.ch = CH_SLASH;
      CH_B:     e.ch = MAP_BS;
      CH_F:     e.ch = MAP_FF;
      CH_N:     e.ch = MAP_LF;
      CH_R:     e.ch = MAP_CR;
      CH_T:     e.ch = MAP_HT;
      default: begin
        e.known = 1'b0;
        e.ch    = '0;
      end
    endcase
    return e;
  endfunction

endpackage

// File: rtl/core/jsu_front.sv
module jsu_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           q_full,
  input  logic           in_req_type,
  input  logic [7:0]     in_byte,
  output logic           push,
  output jsu_pkg::pkt_t  pkt
);
  import jsu_pkg::*;

  // parser modes
  localparam logic [2:0] MODE_IDLE           = 3'd0;
  localparam logic [2:0] MODE_STRING         = 3'd1;
  localparam logic [2:0] MODE_ESCAPE         = 3'd2;
  localparam logic [2:0] MODE_HEX            = 3'd3;
  localparam logic [2:0] MODE_AFTER_HIGH     = 3'd4;
  localparam logic [2:0] MODE_AFTER_HIGH_BSL = 3'd5;

  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  high_r, high_nxt;
  logic        low_r, low_nxt;

  logic               accept;
  logic               lone;
  logic               clr;
  logic               do_raw;
  logic               do_esc;
  res_t [MAX_RES-1:0] tail;
  logic [CNTW-1:0]    tail_n;
  hex_t               dig;
  esc_t               esc;
  logic [15:0]        acc_sh;
  utf8_t              lone_u;
  utf8_t              hex_u;
  logic [20:0]        hex_cp;

  assign accept = in_valid && !q_full;

  // decode one request
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    high_nxt = high_r;
    low_nxt  = low_r;
    lone     = 1'b0;
    clr      = 1'b0;
    do_raw   = 1'b0;
    do_esc   = 1'b0;
    tail     = '0;
    tail_n   = '0;
    hex_cp   = '0;
    dig      = jsu_hex(in_byte);
    esc      = jsu_esc(in_byte);
    acc_sh   = {acc_r[11:0], dig.val};
    lone_u   = jsu_utf8({5'b0, HIGH_SURR_MIN[15:10], high_r});

    if (low_r) begin
      hex_cp = PAIR_OFFSET + {1'b0, high_r, acc_sh[9:0]};
    end else begin
      hex_cp = {5'b0, acc_sh};
    end
    hex_u = jsu_utf8(hex_cp);

    case (mode_r)
      MODE_STRING: begin
        if (in_req_type) begin
          tail[0] = res_err(ERR_UNCLOSED);
          tail_n  = CNTW'(1);
          clr     = 1'b1;
        end else begin
          do_raw = 1'b1;
        end
      end
      MODE_ESCAPE: begin
        if (in_req_type) begin
          tail[0] = res_err(ERR_INCOMPLETE);
          tail_n  = CNTW'(1);
          clr     = 1'b1;
        end else begin
          do_esc = 1'b1;
        end
      end
      MODE_HEX: begin
        if (in_req_type) begin
          lone    = low_r;
          tail[0] = res_err(ERR_SHORT_UNI);
          tail_n  = CNTW'(1);
          clr     = 1'b1;
        end else if (!dig.ok) begin
          tail[0] = res_err(ERR_BAD_HEX);
          tail_n  = CNTW'(1);
          clr     = 1'b1;
        end else if (cnt_r != 2'd3) begin
          acc_nxt = acc_sh;
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          acc_nxt = '0;
          cnt_nxt = '0;
          if (low_r) begin
            if (acc_sh inside {[LOW_SURR_MIN:LOW_SURR_MAX]}) begin
              for (int i = 0; i < MAX_RES; i++) begin
                tail[i] = res_byte(hex_u.b[i]);
              end
              tail_n   = hex_u.n;
              high_nxt = '0;
              low_nxt  = 1'b0;
              mode_nxt = MODE_STRING;
            end else begin
              tail[0] = res_err(ERR_BAD_PAIR);
              tail_n  = CNTW'(1);
              clr     = 1'b1;
            end
          end else if (acc_sh inside {[HIGH_SURR_MIN:HIGH_SURR_MAX]}) begin
            high_nxt = acc_sh[9:0];
            mode_nxt = MODE_AFTER_HIGH;
          end else begin
            for (int i = 0; i < MAX_RES; i++) begin
              tail[i] = res_byte(hex_u.b[i]);
            end
            tail_n   = hex_u.n;
            mode_nxt = MODE_STRING;
          end
        end
      end
      MODE_AFTER_HIGH: begin
        if (in_req_type) begin
          lone    = 1'b1;
          tail[0] = res_err(ERR_UNCLOSED);
          tail_n  = CNTW'(1);
          clr     = 1'b1;
        end else if (in_byte == CH_BSL) begin
          mode_nxt = MODE_AFTER_HIGH_BSL;
        end else begin
          lone     = 1'b1;
          high_nxt = '0;
          mode_nxt = MODE_STRING;
          do_raw   = 1'b1;
        end
      end
      MODE_AFTER_HIGH_BSL: begin
        if (in_req_type) begin
          lone    = 1'b1;
          tail[0] = res_err(ERR_INCOMPLETE);
          tail_n  = CNTW'(1);
          clr     = 1'b1;
        end else if (in_byte == CH_U) begin
          mode_nxt = MODE_HEX;
          low_nxt  = 1'b1;
          acc_nxt  = '0;
          cnt_nxt  = '0;
        end else begin
          lone     = 1'b1;
          high_nxt = '0;
          mode_nxt = MODE_STRING;
          do_esc   = 1'b1;
        end
      end
      default: begin
        if (in_req_type || in_byte != CH_QUOTE) begin
          tail[0] = res_err(ERR_NO_OPEN);
          tail_n  = CNTW'(1);
          clr     = 1'b1;
        end else begin
          mode_nxt = MODE_STRING;
        end
      end
    endcase

    // plain string byte
    if (do_raw) begin
      if (in_byte == CH_QUOTE) begin
        tail[0] = res_end();
        tail_n  = CNTW'(1);
        clr     = 1'b1;
      end else if (in_byte < CTRL_LIMIT) begin
        tail[0] = res_err(ERR_CONTROL);
        tail_n  = CNTW'(1);
        clr     = 1'b1;
      end else if (in_byte == CH_BSL) begin
        mode_nxt = MODE_ESCAPE;
      end else begin
        tail[0] = res_byte(in_byte);
        tail_n  = CNTW'(1);
      end
    end

    // character after a backslash
    if (do_esc) begin
      if (esc.known) begin
        tail[0]  = res_byte(esc.ch);
        tail_n   = CNTW'(1);
        mode_nxt = MODE_STRING;
      end else if (in_byte == CH_U) begin
        mode_nxt = MODE_HEX;
        low_nxt  = 1'b0;
        acc_nxt  = '0;
        cnt_nxt  = '0;
      end else begin
        tail[0] = res_err(ERR_UNKNOWN);
        tail_n  = CNTW'(1);
        clr     = 1'b1;
      end
    end

    // error or closing quote drops back to idle
    if (clr) begin
      mode_nxt = MODE_IDLE;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      high_nxt = '0;
      low_nxt  = 1'b0;
    end
  end

  // packet build, lone surrogate bytes go first
  always_comb begin
    pkt = '0;
    if (lone) begin
      pkt.n = CNTW'(LONE_BYTES) + tail_n;
      for (int i = 0; i < LONE_BYTES; i++) begin
        pkt.ent[i] = res_byte(lone_u.b[i]);
      end
      pkt.ent[LONE_BYTES] = tail[0];
    end else begin
      pkt.n   = tail_n;
      pkt.ent = tail;
    end
  end

  assign push = accept && (pkt.n != '0);

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      cnt_r  <= '0;
      high_r <= '0;
      low_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pkt_size: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (pkt.n != '0 && pkt.n <= CNTW'(MAX_RES)))
    else $error("packet size out of range");
  a_hex_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_HEX) |-> (cnt_r == '0 && acc_r == '0))
    else $error("hex accumulator left dirty outside hex mode");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (high_r == '0 && !low_r))
    else $error("surrogate state held while idle");
`endif

endmodule

// File: rtl/core/jsu_queue.sv
module jsu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jsu_pkg::pkt_t     push_pkt,
  input  logic              pop,
  output jsu_pkg::pkt_t     head,
  output jsu_pkg::q_stat_t  stat
);
  import jsu_pkg::*;

  pkt_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] fill_r, fill_nxt;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + QCW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // packet storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == QCW'(QDEPTH));

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= QCW'(QDEPTH))
    else $error("queue fill beyond depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");
`endif

endmodule

// File: rtl/core/jsu_back.sv
module jsu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  jsu_pkg::pkt_t  head,
  input  logic           q_empty,
  input  logic           out_stall,
  output logic           pop,
  output logic           out_valid,
  output logic [7:0]     out_byte,
  output logic           out_byte_valid,
  output logic           out_string_end,
  output logic [3:0]     out_error_code,
  output logic           out_last
);
  import jsu_pkg::*;

  logic [IDXW-1:0] idx_r, idx_nxt;
  res_t            cur;
  logic            take;

  // current result of the head packet
  assign cur            = head.ent[idx_r];
  assign out_valid      = !q_empty;
  assign out_byte       = cur.out_byte;
  assign out_byte_valid = cur.byte_valid;
  assign out_string_end = cur.string_end;
  assign out_error_code = cur.error_code;
  assign out_last       = ({1'b0, idx_r} + CNTW'(1)) == head.n;

  assign take = out_valid && !out_stall;
  assign pop  = take && out_last;

  // walk through the packet, one result on each output transfer not stalled
  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = out_last ? '0 : idx_r + IDXW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> ({1'b0, idx_r} < head.n))
    else $error("result index outside head packet");
`endif

endmodule

// File: rtl/core/json_string_unescape_top.sv
// json string unescaper
// input channel: in_valid / in_stall with in_req_type (0 data byte, 1 end of
// input) and in_byte; one request is taken per cycle while in_stall is low.
// the text must start with an opening quote; raw bytes, simple escapes and
// \uXXXX escapes (with surrogate pairing) come out as utf-8 bytes.
// result channel: out_valid / out_stall with out_byte, out_byte_valid,
// out_string_end, out_error_code and out_last (last result of a request).
// each input request yields 0 to 4 results; they are gathered into one packet
// and held in a 4-entry packet queue between the parser and the output side.
// the results of a request are registered in the packet queue before they are
// offered. the input side takes one request per cycle while in_stall is low;
// the output side delivers one result per cycle while out_stall is low, so
// streams of multi-result requests are paced by it, bursts absorbed by the queue.
// when the receiver stalls, results hold steady and the queue fills;
// in_stall rises once four packets are waiting.
// reset (rst_n low, synchronous) empties the queue and returns the parser to
// idle, awaiting an opening quote.
module json_string_unescape_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_string_end,
  output logic [3:0] out_error_code,
  output logic       out_last
);
  import jsu_pkg::*;

  logic    push;
  logic    pop;
  pkt_t    push_pkt;
  pkt_t    head;
  q_stat_t q_stat;

  assign in_stall = q_stat.full;

  // parser
  jsu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .q_full      (q_stat.full),
    .in_req_type (in_req_type),
    .in_byte     (in_byte),
    .push        (push),
    .pkt         (push_pkt)
  );

  // packet queue
  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // result serialiser
  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_empty        (q_stat.empty),
    .out_stall      (out_stall),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_string_end (out_string_end),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule
